// ----- rtl/core/lctss_pkg.sv -----
// shared widths, field codes and constants for the load cell tare/span scaler
// no dependencies; imported by every module of the block
package lctss_pkg;

  // field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned RegW    = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned ProdW   = RegW + LevelW;
  localparam int unsigned NumW    = SampleW + LevelW;
  localparam int unsigned QuotW   = LevelW + 1;

  // converter conversion constants
  localparam logic [SampleW-1:0] SignFlip = 24'h800000;
  localparam logic [SampleW-1:0] ReadMask = 24'hFFFFF8;
  localparam logic [LevelW-1:0]  LevelMax = 8'd255;

  // register reset values and gain special codes
  localparam logic [RegW-1:0] GainNom  = 16'd256;
  localparam logic [RegW-1:0] GainBad  = 16'hFFFF;
  localparam logic [RegW-1:0] FsReset  = 16'd5000;

  // configuration register indexes
  localparam logic RegGain = 1'b0;
  localparam logic RegFs   = 1'b1;

  // item modes
  localparam logic [ModeW-1:0] ModeMeasure = 2'd0;
  localparam logic [ModeW-1:0] ModeTare    = 2'd1;
  localparam logic [ModeW-1:0] ModeSpan    = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] StatMeasured = 2'd0;
  localparam logic [StatW-1:0] StatTare     = 2'd1;
  localparam logic [StatW-1:0] StatSpan     = 2'd2;
  localparam logic [StatW-1:0] StatSpanErr  = 2'd3;

endpackage

// ----- rtl/core/lctss_div.sv -----
// bit-serial restoring divider: level = (diff * 255) / span, saturated at 255
// depends on lctss_pkg; one quotient bit per cycle
module lctss_div import lctss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SampleW-1:0] num_i,
  input  logic [SampleW-1:0] den_i,
  output logic               done_o,
  output logic [LevelW-1:0]  level_o
);

  logic [NumW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]  dvs_q, dvs_d;
  logic [QuotW-1:0] quo_q, quo_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             fits;

  // one restoring step per cycle against the shifting divisor
  assign fits = (rem_q >= dvs_q);

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // numerator times 255 as (n << 8) - n
      rem_d  = {num_i, {LevelW{1'b0}}} - {{LevelW{1'b0}}, num_i};
      dvs_d  = {den_i, {LevelW{1'b0}}};
      quo_d  = '0;
      cnt_d  = 4'(QuotW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dvs_q;
      end
      quo_d = {quo_q[QuotW-2:0], fits};
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  // top quotient bit set means the ratio is 256 or more
  assign done_o  = done_q;
  assign level_o = quo_q[QuotW-1] ? LevelMax : quo_q[LevelW-1:0];

endmodule

// ----- rtl/core/lctss_mul.sv -----
// bit-serial shift-add multiplier, two lanes sharing the level multiplier bits
// depends on lctss_pkg; one level bit per cycle
module lctss_mul import lctss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LevelW-1:0] level_i,
  input  logic [RegW-1:0]   gain_i,
  input  logic [RegW-1:0]   fs_i,
  output logic              done_o,
  output logic [ProdW-1:0]  gain_prod_o,
  output logic [ProdW-1:0]  fs_prod_o
);

  logic [LevelW-1:0] lvl_q, lvl_d;
  logic [ProdW-1:0]  mc_g_q, mc_g_d, mc_f_q, mc_f_d;
  logic [ProdW-1:0]  acc_g_q, acc_g_d, acc_f_q, acc_f_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // add the shifted multiplicands when the current level bit is set
  always_comb begin
    lvl_d   = lvl_q;
    mc_g_d  = mc_g_q;
    mc_f_d  = mc_f_q;
    acc_g_d = acc_g_q;
    acc_f_d = acc_f_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      lvl_d   = level_i;
      mc_g_d  = {{LevelW{1'b0}}, gain_i};
      mc_f_d  = {{LevelW{1'b0}}, fs_i};
      acc_g_d = '0;
      acc_f_d = '0;
      cnt_d   = 3'(LevelW - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (lvl_q[0]) begin
        acc_g_d = acc_g_q + mc_g_q;
        acc_f_d = acc_f_q + mc_f_q;
      end
      lvl_d  = lvl_q >> 1;
      mc_g_d = mc_g_q << 1;
      mc_f_d = mc_f_q << 1;
      cnt_d  = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    mc_g_q  <= mc_g_d;
    mc_f_q  <= mc_f_d;
    acc_g_q <= acc_g_d;
    acc_f_q <= acc_f_d;
  end

  assign done_o      = done_q;
  assign gain_prod_o = acc_g_q;
  assign fs_prod_o   = acc_f_q;

endmodule

// ----- rtl/core/load_cell_tare_span_scaler_unit.sv -----
// load cell tare/span scaler: one result per item; from input transfer to output
// valid the item passes the update, the check, a 9-step serial divide when a divide
// runs and an 8-step serial multiply, each serial unit ending with a done strobe,
// then the output load; the divide is skipped when span is unset or the reading is
// not above zero; one item in flight; the next input transfer comes the cycle after the result loads
// async active-low reset clears zero offset and span, gain to 256, full scale 5000
module load_cell_tare_span_scaler_unit import lctss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [23:0] reading, [31:24] level,
                                      // [39:32] dac_code, [55:40] millivolts
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StPrep = 6'b000010,
    StCalc = 6'b000100,
    StDiv  = 6'b001000,
    StMul  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [RegW-1:0]    gain_q, fs_q;
  logic [SampleW-1:0] zero_q, zero_d, span_q, span_d;
  logic [SampleW-1:0] reading_q, reading_d;
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [StatW-1:0]   status_q, status_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic [LevelW-1:0]  dac_q, dac_d;
  logic [RegW-1:0]    mv_q, mv_d;
  logic               m_valid_q, m_valid_d;
  logic [55:0]        m_data_q, m_data_d;
  logic [StatW-1:0]   m_user_q, m_user_d;

  logic               s_xfer, out_free;
  logic               div_start, div_done, mul_start, mul_done;
  logic [LevelW-1:0]  div_level, mul_level;
  logic [RegW-1:0]    gain_eff;
  logic [ProdW-1:0]   gain_prod, fs_prod;

  assign s_axis_tready = (state_q == StIdle);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // zero and all-ones gain codes fall back to the nominal gain
  assign gain_eff  = (gain_q == '0 || gain_q == GainBad) ? GainNom : gain_q;
  assign mul_level = (state_q == StDiv) ? div_level : '0;

  // sequencer
  always_comb begin
    state_d   = state_q;
    zero_d    = zero_q;
    span_d    = span_q;
    reading_d = reading_q;
    mode_d    = mode_q;
    status_d  = status_q;
    level_d   = level_q;
    dac_d     = dac_q;
    mv_d      = mv_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    div_start = 1'b0;
    mul_start = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_xfer) begin
          reading_d = (s_axis_tdata ^ SignFlip) & ReadMask;
          mode_d    = s_axis_tuser;
          state_d   = StPrep;
        end
      end
      StPrep: begin
        // tare or span update ahead of the level
        status_d = StatMeasured;
        if (mode_q == ModeTare) begin
          zero_d   = reading_q;
          status_d = StatTare;
        end else if (mode_q == ModeSpan) begin
          if (reading_q > zero_q) begin
            span_d   = reading_q - zero_q;
            status_d = StatSpan;
          end else begin
            status_d = StatSpanErr;
          end
        end
        state_d = StCalc;
      end
      StCalc: begin
        if (span_q != '0 && reading_q > zero_q) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end else begin
          level_d   = '0;
          mul_start = 1'b1;
          state_d   = StMul;
        end
      end
      StDiv: begin
        if (div_done) begin
          level_d   = div_level;
          mul_start = 1'b1;
          state_d   = StMul;
        end
      end
      StMul: begin
        if (mul_done) begin
          dac_d   = (gain_prod[ProdW-1:LevelW] > {{LevelW{1'b0}}, LevelMax})
                    ? LevelMax : gain_prod[2*LevelW-1:LevelW];
          mv_d    = fs_prod[ProdW-1:LevelW];
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {mv_q, dac_q, level_q, reading_q};
          m_user_d  = status_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      zero_q    <= '0;
      span_q    <= '0;
      gain_q    <= GainNom;
      fs_q      <= FsReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      zero_q    <= zero_d;
      span_q    <= span_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegGain) begin
          gain_q <= cfg_data_i;
        end
        if (cfg_idx_i == RegFs) begin
          fs_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    reading_q <= reading_d;
    mode_q    <= mode_d;
    status_q  <= status_d;
    level_q   <= level_d;
    dac_q     <= dac_d;
    mv_q      <= mv_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  lctss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (reading_q - zero_q),
    .den_i   (span_q),
    .done_o  (div_done),
    .level_o (div_level)
  );

  lctss_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .level_i     (mul_level),
    .gain_i      (gain_eff),
    .fs_i        (fs_q),
    .done_o      (mul_done),
    .gain_prod_o (gain_prod),
    .fs_prod_o   (fs_prod)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- verif/load_cell_tare_span_scaler_unit_tb.sv -----
// self-checking testbench for the load cell tare/span scaler unit
// depends on lctss_pkg and load_cell_tare_span_scaler_unit; predicts every result in a
// small scoreboard class and drives both streams with random idle bursts
module load_cell_tare_span_scaler_unit_tb;
  import lctss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // mode code the block does not name: handled as a measurement
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam int unsigned WdLimit   = 2000;
  localparam int unsigned SettleCyc = 30;
  localparam int unsigned PhaseLen  = 180;

  // one result transfer, fields in stream order
  typedef struct packed {
    logic [SampleW-1:0] reading;
    logic [LevelW-1:0]  level;
    logic [LevelW-1:0]  dac_code;
    logic [RegW-1:0]    millivolts;
    logic [StatW-1:0]   status;
  } weigh_result_t;

  // predicted calibration state plus queue of expected weigh results
  class scaler_scoreboard;
    logic [SampleW-1:0] zero_ofs;
    logic [SampleW-1:0] span_cnt;
    logic [RegW-1:0]    gain_reg;
    logic [RegW-1:0]    fs_reg;
    weigh_result_t      weigh_q[$];
    int unsigned        errs;

    function new();
      zero_ofs = '0;
      span_cnt = '0;
      gain_reg = GainNom;
      fs_reg   = FsReset;
      errs     = 0;
    endfunction

    function void set_reg(logic idx, logic [RegW-1:0] val);
      if (idx == RegGain) gain_reg = val;
      else fs_reg = val;
    endfunction

    function int unsigned pending();
      return weigh_q.size();
    endfunction

    // accepted input: update tare/span first, then scale with the new state
    function void note_sample(logic [ModeW-1:0] mode, logic [SampleW-1:0] raw);
      weigh_result_t   r;
      longint unsigned diff;
      longint unsigned lvl;
      longint unsigned dac;
      longint unsigned mv;
      longint unsigned gain;
      r.reading = (raw ^ SignFlip) & ReadMask;
      r.status  = StatMeasured;
      if (mode == ModeTare) begin
        zero_ofs = r.reading;
        r.status = StatTare;
      end else if (mode == ModeSpan) begin
        if (r.reading > zero_ofs) begin
          span_cnt = r.reading - zero_ofs;
          r.status = StatSpan;
        end else begin
          r.status = StatSpanErr;
        end
      end
      lvl = 0;
      if (span_cnt != 0 && r.reading > zero_ofs) begin
        diff = r.reading - zero_ofs;
        lvl  = (diff * 255) / span_cnt;
        if (lvl > 255) lvl = 255;
      end
      gain = gain_reg;
      if (gain_reg == '0 || gain_reg == GainBad) gain = GainNom;
      dac = (lvl * gain) / 256;
      if (dac > 255) dac = 255;
      mv = (lvl * fs_reg) / 256;
      r.level      = lvl[LevelW-1:0];
      r.dac_code   = dac[LevelW-1:0];
      r.millivolts = mv[RegW-1:0];
      weigh_q.push_back(r);
    endfunction

    function void cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errs++;
      end
    endfunction

    // accepted result: compare against the oldest prediction
    function void check_result(weigh_result_t got);
      weigh_result_t exp_r;
      if (weigh_q.size() == 0) begin
        $error("result transfer with no prediction pending (reading 0x%0h)", got.reading);
        errs++;
        return;
      end
      exp_r = weigh_q.pop_front();
      cmp_field("reading", exp_r.reading, got.reading);
      cmp_field("level", exp_r.level, got.level);
      cmp_field("dac_code", exp_r.dac_code, got.dac_code);
      cmp_field("millivolts", exp_r.millivolts, got.millivolts);
      cmp_field("status", exp_r.status, got.status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [23:0] sample
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // [23:0] reading, [31:24] level, [39:32] dac_code,
                               // [55:40] millivolts
  logic [1:0]  m_axis_tuser;   // [1:0] status

  scaler_scoreboard sb = new();
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned quiet_cyc;

  load_cell_tare_span_scaler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // transfer monitor: results checked before the same-edge input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result({m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tdata[39:32],
                         m_axis_tdata[55:40], m_axis_tuser});
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tuser, s_axis_tdata);
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc == WdLimit) begin
      $display("load_cell_tare_span_scaler_unit_tb: errors");
      $finish;
    end
  end

  // result sink with random stall bursts
  initial begin : sink_proc
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        hold = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge; optional idle burst, then hold the item until its transfer
  task automatic drive_item(input logic [ModeW-1:0] mode, input logic [SampleW-1:0] raw);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // converter code that gives a wanted reading, junk in the cleared low bits
  function automatic logic [SampleW-1:0] code_for(longint unsigned rd);
    logic [SampleW-1:0] c;
    if (rd > 64'hFFFFF8) rd = 64'hFFFFF8;
    c = rd[SampleW-1:0] ^ SignFlip;
    c[2:0] = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // mostly tare, span, measure sequences that land inside the calibrated window
  task automatic pick_item(output logic [ModeW-1:0] mode, output logic [SampleW-1:0] raw);
    int unsigned     roll;
    longint unsigned size;
    roll = $urandom_range(0, 99);
    raw  = 24'($urandom());
    if (roll < 8) begin
      mode = ModeTare;
      if ($urandom_range(0, 3) != 0) raw = code_for($urandom_range(0, 24'hC00000));
    end else if (roll < 20) begin
      mode = ModeSpan;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0: size = $urandom_range(1, 2048);
          1: size = $urandom_range(2049, 65536);
          default: size = $urandom_range(65537, 24'hFFFFFF);
        endcase
        raw = code_for(sb.zero_ofs + size);
      end
    end else if (roll < 25) begin
      mode = ModeSpare;
    end else begin
      mode = ModeMeasure;
      if (sb.span_cnt != 0 && $urandom_range(0, 9) < 7)
        raw = code_for(sb.zero_ofs + $urandom_range(0, sb.span_cnt + sb.span_cnt / 8));
    end
  endtask

  // wait for every prediction to be met, let the block settle, then reprogram
  task automatic program_scale(input logic [RegW-1:0] gain, input logic [RegW-1:0] fs);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegGain;
    cfg_data_i <= gain;
    sb.set_reg(RegGain, gain);
    @(negedge clk_i);
    cfg_idx_i  <= RegFs;
    cfg_data_i <= fs;
    sb.set_reg(RegFs, fs);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    logic [ModeW-1:0]   mode;
    logic [SampleW-1:0] raw;
    repeat (n) begin
      @(negedge clk_i);
      pick_item(mode, raw);
      drive_item(mode, raw);
    end
  endtask

  // directed items: span unset, span errors, full-range span, tiny span, saturation
  logic [ModeW-1:0]   dir_mode[19] = '{
    ModeMeasure, ModeMeasure, ModeSpare, ModeSpan, ModeTare, ModeSpan, ModeMeasure,
    ModeMeasure, ModeTare, ModeSpan, ModeSpan, ModeSpan, ModeMeasure, ModeMeasure,
    ModeMeasure, ModeMeasure, ModeSpare, ModeTare, ModeMeasure};
  logic [SampleW-1:0] dir_raw[19] = '{
    24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h800007, 24'h7FFFFF, 24'h7FFFFF,
    24'h000000, 24'h000005, 24'h000003, 24'hFFFFF8, 24'h00000F, 24'h00000C, 24'h7FFFFF,
    24'h000002, 24'h800000, 24'h555555, 24'hAAAAAA, 24'h123456};

  // main sequence
  initial begin : main_proc
    logic [RegW-1:0] scale_gain[7];
    logic [RegW-1:0] scale_fs[7];
    scale_gain    = '{16'd0, 16'hFFFF, 16'd1, 16'd65534, 16'd512, 16'd0, GainNom};
    scale_fs      = '{16'd0, 16'hFFFF, 16'd1, 16'd65535, 16'd2500, 16'd0, FsReset};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegGain;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeMeasure;
    src_idle_pct  = 15;
    snk_idle_pct  = 15;
    quiet_cyc     = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    foreach (dir_raw[i]) begin
      @(negedge clk_i);
      drive_item(dir_mode[i], dir_raw[i]);
    end
    run_random(PhaseLen);

    // one phase per register setting; the fourth and the last run without idling
    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        scale_gain[p] = 16'($urandom_range(1, 16'hFFFE));
        scale_fs[p]   = 16'($urandom_range(1, 16'hFFFF));
      end
      program_scale(scale_gain[p], scale_fs[p]);
      src_idle_pct = (p == 6 || p == 3) ? 0 : $urandom_range(5, 35);
      snk_idle_pct = (p == 6 || p == 3) ? 0 : $urandom_range(5, 35);
      run_random(PhaseLen);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (sb.errs == 0) begin
      $display("load_cell_tare_span_scaler_unit_tb: clean");
    end else begin
      $display("load_cell_tare_span_scaler_unit_tb: errors");
    end
    $finish;
  end

endmodule
